@@ rtl/ppps_pkg.sv @@
`default_nettype none

package ppps_pkg;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int PERIOD_BITS = 8;
    localparam int CODE_W      = 3;
    localparam int NUM_DIV     = 8;
    localparam int SHIFT_W     = 4;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int CAND_W      = PERIOD_BITS + 1;

    // Result packing: found, code, period, achieved, error from bit 0 up
    localparam int OUT_W       = 1 + CODE_W + PERIOD_BITS + 2 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] CLK_RESET = DATA_W'(48000000);
    // Largest quotient that still gives a period in range
    localparam logic [DATA_W-1:0] Q_LIMIT   = DATA_W'(1) << PERIOD_BITS;
    localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(NUM_DIV - 1);

    // Microcode address width and step addresses
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UA_WAIT   = 3'd0;
    localparam logic [UPC_W-1:0] UA_DIVQ   = 3'd1;
    localparam logic [UPC_W-1:0] UA_LATCHQ = 3'd2;
    localparam logic [UPC_W-1:0] UA_TRY    = 3'd3;
    localparam logic [UPC_W-1:0] UA_UPDATE = 3'd4;
    localparam logic [UPC_W-1:0] UA_STEP   = 3'd5;
    localparam logic [UPC_W-1:0] UA_EMIT   = 3'd6;
    localparam logic [UPC_W-1:0] UA_SPARE  = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_LOAD    = 3'd1,
        OP_DIV_Q   = 3'd2,
        OP_LATCH_Q = 3'd3,
        OP_TRY     = 3'd4,
        OP_UPDATE  = 3'd5,
        OP_STEP    = 3'd6,
        OP_EMIT    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_IN   = 2'd1,
        W_DIV  = 2'd2,
        W_OUT  = 2'd3
    } t_wait;

    typedef enum logic [2:0] {
        BR_NEXT   = 3'd0,
        BR_ALWAYS = 3'd1,
        BR_BAD_IN = 3'd2,
        BR_SKIP   = 3'd3,
        BR_MORE   = 3'd4
    } t_br;

    typedef struct packed {
        t_op              op;
        t_wait            wt;
        t_br              br;
        logic [UPC_W-1:0] dest;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic out_free;
        logic bad_in;
        logic skip;
        logic more;
    } t_cond;

    // Control from sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic fire;
        logic in_ready;
    } t_ctrl;

    // Prescaler as a shift: 1, 2, 4, 8, 16, 64, 256, 1024
    function automatic logic [SHIFT_W-1:0] div_shift(input logic [CODE_W-1:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd1;
            3'd2:    s = 4'd2;
            3'd3:    s = 4'd3;
            3'd4:    s = 4'd4;
            3'd5:    s = 4'd6;
            3'd6:    s = 4'd8;
            3'd7:    s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // Control store
    function automatic t_uword urom(input logic [UPC_W-1:0] addr);
        t_uword w;
        case (addr)
            UA_WAIT:   w = '{OP_LOAD,    W_IN,   BR_BAD_IN, UA_EMIT};
            UA_DIVQ:   w = '{OP_DIV_Q,   W_NONE, BR_NEXT,   UA_WAIT};
            UA_LATCHQ: w = '{OP_LATCH_Q, W_DIV,  BR_NEXT,   UA_WAIT};
            UA_TRY:    w = '{OP_TRY,     W_NONE, BR_SKIP,   UA_STEP};
            UA_UPDATE: w = '{OP_UPDATE,  W_DIV,  BR_NEXT,   UA_WAIT};
            UA_STEP:   w = '{OP_STEP,    W_NONE, BR_MORE,   UA_TRY};
            UA_EMIT:   w = '{OP_EMIT,    W_OUT,  BR_ALWAYS, UA_WAIT};
            UA_SPARE:  w = '{OP_NOP,     W_NONE, BR_ALWAYS, UA_WAIT};
            default:   w = '{OP_NOP,     W_NONE, BR_ALWAYS, UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ppps_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle
module ppps_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ppps_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [ppps_pkg::DATA_W-1:0] i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [ppps_pkg::DATA_W-1:0]     o_quo
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [ppps_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [ppps_pkg::DATA_W-1:0]   r_rem, n_rem;
    logic [ppps_pkg::DATA_W-1:0]   r_quo, n_quo;
    logic [ppps_pkg::DATA_W-1:0]   r_den, n_den;
    logic [ppps_pkg::DATA_W:0]     shifted;
    logic [ppps_pkg::DATA_W:0]     diff;
    logic                          ge;

    // Trial subtract
    always_comb begin
        shifted = {r_rem, r_quo[ppps_pkg::DATA_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[ppps_pkg::DATA_W-1:0] : shifted[ppps_pkg::DATA_W-1:0];
            n_quo = {r_quo[ppps_pkg::DATA_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ppps_pkg::DIV_CNT_W'(ppps_pkg::DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // A new division never overwrites one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

@@ rtl/ppps_useq.sv @@
`default_nettype none

// Microprogram sequencer: step counter, control store, conditional jumps
module ppps_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ppps_pkg::t_cond i_cond,
    output ppps_pkg::t_ctrl      o_ctrl
);

    logic [ppps_pkg::UPC_W-1:0] r_upc, n_upc;
    ppps_pkg::t_uword           uw;
    logic                       go;
    logic                       taken;

    assign uw = ppps_pkg::urom(r_upc);

    // Wait condition of the current step
    always_comb begin
        case (uw.wt)
            ppps_pkg::W_NONE: go = 1'b1;
            ppps_pkg::W_IN:   go = i_cond.in_valid;
            ppps_pkg::W_DIV:  go = i_cond.div_done;
            ppps_pkg::W_OUT:  go = i_cond.out_free;
            default:          go = 1'b0;
        endcase
    end

    // Branch condition
    always_comb begin
        case (uw.br)
            ppps_pkg::BR_NEXT:   taken = 1'b0;
            ppps_pkg::BR_ALWAYS: taken = 1'b1;
            ppps_pkg::BR_BAD_IN: taken = i_cond.bad_in;
            ppps_pkg::BR_SKIP:   taken = i_cond.skip;
            ppps_pkg::BR_MORE:   taken = i_cond.more;
            default:             taken = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (go) begin
            n_upc = taken ? uw.dest : r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ppps_pkg::UA_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.op       = uw.op;
    assign o_ctrl.fire     = go;
    assign o_ctrl.in_ready = (uw.wt == ppps_pkg::W_IN);

endmodule

`default_nettype wire

@@ rtl/pwm_prescaler_period_search_top.sv @@
`default_nettype none

// Timer prescaler and period search.
// Write the timer input clock in Hz through i_cfg_we / i_cfg_wdata (reset value
// 48 MHz, zero means unknown) while the block is idle. Each request on the
// s_axis channel carries a target frequency; the block answers with one result
// on m_axis: found flag, prescaler code (1,2,4,8,16,64,256,1024), period,
// achieved frequency and its absolute error. On equal error the smaller
// prescaler wins. Nothing found gives all fields zero.
// One request is worked on at a time. A microprogram drives a single serial
// divider: one division clk/target, then one division per prescaler whose
// period is in range; at most seven prescalers are usable at once. A zero
// target or zero clock skips the divisions and gives an empty result. The
// result sits in an output register, so a stalled receiver only holds the
// block once the next result is ready.
// Reset is synchronous, active low; it restores the clock register to 48 MHz,
// empties the output register and returns the sequencer to its wait step.
module pwm_prescaler_period_search_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ppps_pkg::DATA_W-1:0]      i_cfg_wdata,  // input_clock_hz
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ppps_pkg::DATA_W-1:0]      s_axis_tdata, // target_hz
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // found, prescaler_code, period, achieved_hz, error_hz, zero fill
    output logic [ppps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    ppps_pkg::t_cond cond;
    ppps_pkg::t_ctrl ctrl;

    logic [ppps_pkg::DATA_W-1:0]      r_clk_hz;
    logic [ppps_pkg::DATA_W-1:0]      r_target;
    logic [ppps_pkg::DATA_W-1:0]      r_q;
    logic [ppps_pkg::CODE_W-1:0]      r_idx;
    logic [ppps_pkg::CAND_W-1:0]      r_cand_q;
    logic                             r_found;
    logic [ppps_pkg::CODE_W-1:0]      r_code;
    logic [ppps_pkg::PERIOD_BITS-1:0] r_per;
    logic [ppps_pkg::DATA_W-1:0]      r_ach;
    logic [ppps_pkg::DATA_W-1:0]      r_err;
    logic                             r_m_valid;
    logic [ppps_pkg::OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic [ppps_pkg::SHIFT_W-1:0]     sh;
    logic [ppps_pkg::DATA_W-1:0]      q_cand;
    logic                             skip;
    logic                             div_start;
    logic                             div_busy;
    logic                             div_done;
    logic [ppps_pkg::DATA_W-1:0]      div_quo;
    logic [ppps_pkg::DATA_W-1:0]      div_a;
    logic [ppps_pkg::DATA_W-1:0]      div_b;
    logic [ppps_pkg::DATA_W-1:0]      err;
    logic [ppps_pkg::CAND_W-1:0]      per_full;
    logic                             fire_op_try;
    logic                             out_free;

    // Candidate quotient for the current prescaler: floor(Q / prescaler)
    always_comb begin
        sh     = ppps_pkg::div_shift(r_idx);
        q_cand = r_q >> sh;
        skip   = (q_cand == '0) || (q_cand > ppps_pkg::Q_LIMIT);
    end

    // Divider operand select
    assign fire_op_try = ctrl.fire && (ctrl.op == ppps_pkg::OP_TRY);
    always_comb begin
        if (ctrl.op == ppps_pkg::OP_DIV_Q) begin
            div_a = r_clk_hz;
            div_b = r_target;
        end else begin
            div_a = r_clk_hz >> sh;
            div_b = q_cand;
        end
        div_start = (ctrl.fire && (ctrl.op == ppps_pkg::OP_DIV_Q)) || (fire_op_try && !skip);
    end

    ppps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Error of the candidate just divided
    always_comb begin
        err      = (div_quo >= r_target) ? div_quo - r_target : r_target - div_quo;
        per_full = r_cand_q - 1'b1;
    end

    assign out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        cond.in_valid = s_axis_tvalid;
        cond.div_done = div_done;
        cond.out_free = out_free;
        cond.bad_in   = (s_axis_tdata == '0) || (r_clk_hz == '0);
        cond.skip     = skip;
        cond.more     = (r_idx != ppps_pkg::LAST_CODE);
    end

    ppps_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= ppps_pkg::CLK_RESET;
        end else if (i_cfg_we) begin
            r_clk_hz <= i_cfg_wdata;
        end
    end

    // Datapath registers, driven by the current control word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (ctrl.fire) begin
            case (ctrl.op)
                ppps_pkg::OP_LOAD: begin
                    r_found <= 1'b0;
                    r_idx   <= '0;
                end
                ppps_pkg::OP_UPDATE: begin
                    if (!r_found || (err < r_err)) begin
                        r_found <= 1'b1;
                    end
                end
                ppps_pkg::OP_STEP: begin
                    r_idx <= r_idx + 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (ctrl.fire) begin
            case (ctrl.op)
                ppps_pkg::OP_LOAD: begin
                    r_target <= s_axis_tdata;
                    r_code   <= '0;
                    r_per    <= '0;
                    r_ach    <= '0;
                    r_err    <= '0;
                end
                ppps_pkg::OP_LATCH_Q: begin
                    r_q <= div_quo;
                end
                ppps_pkg::OP_TRY: begin
                    r_cand_q <= q_cand[ppps_pkg::CAND_W-1:0];
                end
                ppps_pkg::OP_UPDATE: begin
                    if (!r_found || (err < r_err)) begin
                        r_code <= r_idx;
                        r_per  <= per_full[ppps_pkg::PERIOD_BITS-1:0];
                        r_ach  <= div_quo;
                        r_err  <= err;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_comb begin
        n_m_data = '0;
        n_m_data[ppps_pkg::OUT_W-1:0] = {r_err, r_ach, r_per, r_code, r_found};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctrl.fire && (ctrl.op == ppps_pkg::OP_EMIT)) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (ctrl.fire && (ctrl.op == ppps_pkg::OP_EMIT)) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A taken request moves the sequencer off its wait step
    a_leave_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer stayed on wait step after a request");

    // No request is taken while a division is running
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_busy)
        else $error("divider busy while waiting for a request");

    // A result without a match carries zero fields
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[ppps_pkg::OUT_W-1:1] == '0))
        else $error("nonzero fields in a result without a match");

endmodule

`default_nettype wire
